/* src/tffe_pkg.sv */
// Shared types for the tight fusion frame existence test unit.
`default_nettype none

package tffe_pkg;

    // Status that the divider reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } tffe_div_stat_t;

endpackage

`default_nettype wire

/* src/tffe_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module tffe_div #(
    parameter int WIDTH = 12
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [WIDTH-1:0]      dividend,
    input  wire logic [WIDTH-1:0]      divisor,
    output tffe_pkg::tffe_div_stat_t   stat,
    output logic [WIDTH-1:0]           quotient,
    output logic [WIDTH-1:0]           remainder
);
    import tffe_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // A finished division leaves a remainder below a nonzero divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && dvs_reg != '0) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // Busy and done never overlap.
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

    // The last step of a division raises done in the next cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == CNT_W'(1)) |=> done_reg)
        else $error("divider missed its done pulse");

endmodule

`default_nettype wire

/* src/tight_fusion_frame_existence_test_unit.sv */
// Top level of the tight fusion frame existence test unit.
// Each input transaction carries a triple (k, l, n) and yields one output
// transaction: exists in m_tdata bit 0 and bad_args in m_tuser. An invalid
// triple (k = 0, l = 0 or l >= n) goes to the done state without a division.
// A valid triple runs rounds of the restoring divider on n / l; each round
// is a start, one quotient bit per cycle while the divider is busy, and a
// decision, and the number of rounds is data dependent, at most the reduced
// l. The unit holds s_tready low from the accepted input transaction until
// its result has been loaded into the output register; one item is in work
// at a time.
`default_nettype none

module tight_fusion_frame_existence_test_unit #(
    parameter int VALUE_WIDTH = 12
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // s_tdata: frame_count, sub_dim, amb_dim from the lowest bit up.
    input  wire logic [((3*VALUE_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    // m_tdata: exists in bit 0, zero padding above.
    output logic [7:0]                                     m_tdata,
    // m_tuser: bad_args.
    output logic                                           m_tuser
);
    import tffe_pkg::*;

    localparam int W = VALUE_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GO   = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]   state_reg, state_next;
    logic [W-1:0] k_reg, k_next;
    logic [W-1:0] l_reg, l_next;
    logic [W-1:0] n_reg, n_next;
    logic         res_exists_reg, res_exists_next;
    logic         res_bad_reg, res_bad_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_exists_reg, out_exists_next;
    logic         out_bad_reg, out_bad_next;

    logic [W-1:0]   in_k, in_l, in_n;
    logic           in_bad;
    logic [W:0]     in_l_dbl;
    logic           in_accept;
    logic           div_start;
    tffe_div_stat_t div_stat;
    logic [W-1:0]   div_q, div_r;
    logic [W:0]     q_plus2;
    logic [W:0]     k_ext;
    logic [W:0]     n_round;

    // Unpack the input transaction.
    assign in_k      = s_tdata[W-1:0];
    assign in_l      = s_tdata[2*W-1:W];
    assign in_n      = s_tdata[3*W-1:2*W];
    assign in_bad    = (in_k == '0) || (in_l == '0) || (in_l >= in_n);
    assign in_l_dbl  = {in_l, 1'b0};
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // Decision terms for a finished division n = q*l + r.
    assign q_plus2 = {1'b0, div_q} + (W+1)'(2);
    assign k_ext   = {1'b0, k_reg};
    // With k = q + 2 the new n is k*l - n = 2l - r.
    assign n_round = {l_reg, 1'b0} - {1'b0, div_r};

    assign div_start = (state_reg == ST_GO);

    tffe_div #(
        .WIDTH (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (l_reg),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        l_next          = l_reg;
        n_next          = n_reg;
        res_exists_next = res_exists_reg;
        res_bad_next    = res_bad_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_exists_next = out_exists_reg;
        out_bad_next    = out_bad_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    k_next = in_k;
                    n_next = in_n;
                    l_next = (in_l_dbl > {1'b0, in_n}) ? (in_n - in_l) : in_l;
                    if (in_bad)
                    begin
                        res_exists_next = 1'b0;
                        res_bad_next    = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        res_bad_next = 1'b0;
                        state_next   = ST_GO;
                    end
                end
            end
            ST_GO:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_stat.done)
                begin
                    priority if (div_r == '0)
                    begin
                        res_exists_next = (k_reg >= div_q);
                        state_next      = ST_DONE;
                    end
                    else if (k_ext > q_plus2)
                    begin
                        res_exists_next = 1'b1;
                        state_next      = ST_DONE;
                    end
                    else if (k_ext < q_plus2)
                    begin
                        res_exists_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        n_next     = n_round[W-1:0];
                        l_next     = l_reg - div_r;
                        state_next = ST_GO;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_exists_next = res_exists_reg;
                    out_bad_next    = res_bad_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        l_reg          <= l_next;
        n_reg          <= n_next;
        res_exists_reg <= res_exists_next;
        res_bad_reg    <= res_bad_next;
        out_exists_reg <= out_exists_next;
        out_bad_reg    <= out_bad_next;
    end

    // Output transaction.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_exists_reg};
    assign m_tuser  = out_bad_reg;

    // An invalid triple never reports that a frame exists.
    a_bad_not_exists: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_bad_reg && out_exists_reg))
        else $error("bad_args and exists both set");

    // The divider is only started when it is idle.
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A division result only arrives while the sequencer waits for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_WAIT))
        else $error("divider done outside the wait state");

    // The subspace dimension under test stays nonzero during a round.
    a_l_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GO) |-> (l_reg != '0))
        else $error("division started with a zero divisor");

endmodule

`default_nettype wire
